[rtl/core/bsdcp_pkg.sv]
// shared constants and types for the b-spline derivative control point block
// no dependencies
`timescale 1ns / 1ps
package bsdcp_pkg;
  localparam int MaxPointsDef = 64;
  localparam int MaxKnotsDef  = 128;
  localparam int MaxOrderDef  = 7;

  typedef enum logic [1:0] {
    ACT_LOAD_KNOT  = 2'd0,
    ACT_LOAD_POINT = 2'd1,
    ACT_COMPUTE    = 2'd2,
    ACT_READ       = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SPAN = 2'd1;
  localparam logic [1:0] ST_OUTSIDE   = 2'd2;

  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_ORDER  = 2'd1;
  localparam logic [1:0] REG_FIRST  = 2'd2;
  localparam logic [1:0] REG_LAST   = 2'd3;
endpackage

[rtl/core/bspline_derivative_control_points.sv]
// b-spline derivative control points: knot, point and triangle memories with a sequencer
// loads write at accept; reads go via S_READ, reads outside the triangle answer at the accepting edge
// compute: copy range to row 0, then read, divide and write each entry; empty range at once
// throughput: one item at a time; compute time is set by the shared bit-serial divider
// reset: synchronous active low, clears config to defaults, flags and triangle valid
`timescale 1ns / 1ps
module bspline_derivative_control_points
  import bsdcp_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int MAX_KNOTS  = MaxKnotsDef,
  parameter int MAX_ORDER  = MaxOrderDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [6:0]         in_index,
  input  logic signed [31:0] in_knot_value,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [2:0]         in_read_order,
  input  logic [5:0]         in_read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [1:0]         status
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int KW = $clog2(MAX_KNOTS);
  localparam int TD = (MAX_ORDER + 1) * MAX_POINTS;
  localparam int TW = $clog2(TD);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_COPYR = 9'b000000010,
    S_COPYW = 9'b000000100,
    S_RD0   = 9'b000001000,
    S_RD1   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_READ  = 9'b010000000,
    S_READW = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] degree_r, order_r;
  logic [5:0] first_r, last_r;
  logic       zflag_r, zflag_nxt;
  logic       tvalid_r, tvalid_nxt;
  logic signed [11:0] trange_r, trange_nxt;
  logic [3:0] torder_r, torder_nxt;
  logic       ov_r, ov_nxt;
  logic [95:0] od_r, od_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [11:0] i_r, i_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [1:0]  c_r, c_nxt;
  logic [95:0] a_r, a_nxt;
  logic signed [32:0] span_r, span_nxt;
  logic signed [95:0] res_r, res_nxt;

  // memories
  logic          kwe, pwe, twe;
  logic [KW-1:0] kwa, kra;
  logic [31:0]   krd;
  logic [PW-1:0] pwa, pra;
  logic [95:0]   prd, trd, twd;
  logic [TW-1:0] twa, tra;

  bsdcp_ram #(.Width(32), .Depth(MAX_KNOTS)) u_knot (
    .clk, .we(kwe), .waddr(kwa), .wdata(in_knot_value), .raddr(kra), .rdata(krd));
  bsdcp_ram #(.Width(96), .Depth(MAX_POINTS)) u_point (
    .clk, .we(pwe), .waddr(pwa), .wdata({in_coord_z, in_coord_y, in_coord_x}),
    .raddr(pra), .rdata(prd));
  bsdcp_ram #(.Width(96), .Depth(TD)) u_tri (
    .clk, .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd));

  // second knot port is emulated by a second knot memory copy
  logic [KW-1:0] kra2;
  logic [31:0]   krd2;
  bsdcp_ram #(.Width(32), .Depth(MAX_KNOTS)) u_knot2 (
    .clk, .we(kwe), .waddr(kwa), .wdata(in_knot_value), .raddr(kra2), .rdata(krd2));

  // triangle b port via a duplicate
  logic [TW-1:0] tra2;
  logic [95:0]   trd2;
  bsdcp_ram #(.Width(96), .Depth(TD)) u_tri2 (
    .clk, .we(twe), .waddr(twa), .wdata(twd), .raddr(tra2), .rdata(trd2));

  function automatic logic [TW-1:0] taddr(input logic [3:0] k, input logic [11:0] i);
    logic [TW+3:0] t;
    t = (TW+4)'(k) * (TW+4)'(MAX_POINTS) + (TW+4)'(i);
    return t[TW-1:0];
  endfunction

  // combinational helpers
  logic [11:0] rng_raw;
  logic signed [11:0] rng_s;
  logic [3:0]  ord_c;
  logic [11:0] base, kidx_hi, kidx_lo;
  logic signed [32:0] kh, kl, span_c;
  logic signed [33:0] diff;
  logic signed [4:0]  factor;
  logic signed [52:0] num;
  logic        dstart, ddone;
  logic signed [52:0] quot;
  logic signed [31:0] sq;
  logic        accept;
  logic signed [12:0] rlim;

  bsdcp_div u_div (.clk, .rst_n, .start(dstart), .num(num), .den(span_r),
    .done(ddone), .quot(quot));

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_x = od_r[31:0];
  assign out_y = od_r[63:32];
  assign out_z = od_r[95:64];
  assign status = ost_r;

  always_comb begin
    rng_s = $signed({6'd0, last_r}) - $signed({6'd0, first_r});
    if (rng_s > 12'(MAX_POINTS - 1)) rng_s = 12'(MAX_POINTS - 1);
    rng_raw = 12'(rng_s);
    ord_c = (4'(order_r) > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : 4'(order_r);
    base = 12'(first_r) + i_r;
    kidx_hi = base + 12'(degree_r) + 12'd1;
    kidx_lo = base + 12'(k_r);
    kh = (kidx_hi < 12'(MAX_KNOTS)) ? 33'(signed'(krd)) : '0;
    kl = (kidx_lo < 12'(MAX_KNOTS)) ? 33'(signed'(krd2)) : '0;
    span_c = kh - kl;
    factor = 5'(degree_r) - 5'(k_r) + 5'd1;
    case (c_r)
      2'd0: diff = 34'(signed'(a_r[31:0])) - 34'(signed'(trd2[31:0]));
      2'd1: diff = 34'(signed'(a_r[63:32])) - 34'(signed'(trd2[63:32]));
      default: diff = 34'(signed'(a_r[95:64])) - 34'(signed'(trd2[95:64]));
    endcase
    num = 53'(diff * factor) <<< 16;
    if (quot > 53'sh7FFFFFFF) sq = 32'sh7FFFFFFF;
    else if (quot < -53'sh80000000) sq = 32'sh80000000;
    else sq = quot[31:0];
    rlim = 13'(trange_r) - 13'(in_read_order);
  end

  always_comb begin
    state_nxt = state_r;
    zflag_nxt = zflag_r;
    tvalid_nxt = tvalid_r;
    trange_nxt = trange_r;
    torder_nxt = torder_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    ost_nxt = ost_r;
    i_nxt = i_r;
    k_nxt = k_r;
    c_nxt = c_r;
    a_nxt = a_r;
    span_nxt = span_r;
    res_nxt = res_r;
    kwe = 1'b0; kwa = in_index[KW-1:0];
    pwe = 1'b0; pwa = in_index[PW-1:0];
    twe = 1'b0; twa = '0; twd = prd;
    kra = kidx_hi[KW-1:0];
    kra2 = kidx_lo[KW-1:0];
    pra = base[PW-1:0];
    tra = taddr(k_r - 4'd1, i_r + 12'd1);
    tra2 = taddr(k_r - 4'd1, i_r);
    dstart = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_LOAD_KNOT: kwe = 12'(in_index) < 12'(MAX_KNOTS);
            ACT_LOAD_POINT: pwe = 12'(in_index) < 12'(MAX_POINTS);
            ACT_COMPUTE: begin
              zflag_nxt = 1'b0;
              tvalid_nxt = 1'b1;
              trange_nxt = rng_s;
              torder_nxt = ord_c;
              i_nxt = '0;
              if (rng_s < 0) begin
                ov_nxt = 1'b1; od_nxt = '0; ost_nxt = ST_OK;
              end else begin
                state_nxt = S_COPYR;
              end
            end
            default: begin
              tra = taddr(4'(in_read_order), 12'(in_read_index));
              if (tvalid_r && 4'(in_read_order) <= torder_r
                  && $signed({7'd0, in_read_index}) <= rlim) begin
                state_nxt = S_READ;
              end else begin
                ov_nxt = 1'b1; od_nxt = '0; ost_nxt = ST_OUTSIDE;
              end
            end
          endcase
        end
      end
      S_READ: begin
        ov_nxt = 1'b1; od_nxt = trd;
        ost_nxt = zflag_r ? ST_ZERO_SPAN : ST_OK;
        state_nxt = S_IDLE;
      end
      S_COPYR: state_nxt = S_COPYW;
      S_COPYW: begin
        twe = 1'b1;
        twa = taddr(4'd0, i_r);
        twd = (base < 12'(MAX_POINTS)) ? prd : '0;
        if (i_r == rng_raw) begin
          i_nxt = '0;
          if (torder_r >= 4'd1 && rng_raw >= 12'd1) begin
            k_nxt = 4'd1;
            state_nxt = S_RD0;
          end else begin
            k_nxt = 4'd0;
            state_nxt = S_WAIT;
          end
        end else begin
          i_nxt = i_r + 12'd1;
          state_nxt = S_COPYR;
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: begin
        // memory outputs valid: latch upper neighbor and span
        a_nxt = trd;
        span_nxt = span_c;
        c_nxt = 2'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (span_r == 0) begin
          res_nxt = '0;
          zflag_nxt = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          dstart = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (k_r == 4'd0 || span_r == 0 || ddone) begin
          if (span_r != 0 && k_r != 4'd0) begin
            case (c_r)
              2'd0: res_nxt[31:0] = sq;
              2'd1: res_nxt[63:32] = sq;
              default: res_nxt[95:64] = sq;
            endcase
          end
          if (k_r != 4'd0 && span_r != 0 && c_r != 2'd2) begin
            c_nxt = c_r + 2'd1;
            state_nxt = S_DIV;
          end else if (k_r == 4'd0 || torder_r < 4'd1 || rng_raw < 12'd1) begin
            ov_nxt = 1'b1; od_nxt = '0;
            ost_nxt = zflag_r ? ST_ZERO_SPAN : ST_OK;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READW;
          end
        end
      end
      default: begin
        // write the finished entry, advance i and k
        twe = 1'b1;
        twa = taddr(k_r, i_r);
        twd = (span_r == 0) ? '0 : res_nxt;
        if (i_r + 12'(k_r) >= rng_raw) begin
          i_nxt = '0;
          if (k_r >= torder_r || 12'(k_r) + 12'd1 > rng_raw) begin
            k_nxt = 4'd0;
            state_nxt = S_WAIT;
          end else begin
            k_nxt = k_r + 4'd1;
            state_nxt = S_RD0;
          end
        end else begin
          i_nxt = i_r + 12'd1;
          state_nxt = S_RD0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      degree_r <= 3'd3;
      order_r <= 3'd1;
      first_r <= 6'd0;
      last_r <= 6'd63;
      zflag_r <= 1'b0;
      tvalid_r <= 1'b0;
      trange_r <= -12'sd1;
      torder_r <= '0;
      ov_r <= 1'b0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DEGREE: degree_r <= cfg_data[2:0];
          REG_ORDER:  order_r <= cfg_data[2:0];
          REG_FIRST:  first_r <= cfg_data;
          REG_LAST:   last_r <= cfg_data;
          default: ;
        endcase
      end
      zflag_r <= zflag_nxt;
      tvalid_r <= tvalid_nxt;
      trange_r <= trange_nxt;
      torder_r <= torder_nxt;
      ov_r <= ov_nxt;
      k_r <= k_nxt;
    end
    od_r <= od_nxt;
    ost_r <= ost_nxt;
    i_r <= i_nxt;
    c_r <= c_nxt;
    a_r <= a_nxt;
    span_r <= span_nxt;
    res_r <= res_nxt;
  end
endmodule

[rtl/core/bsdcp_ram.sv]
// generic single-port-write, single-read synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
module bsdcp_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/bsdcp_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// does not use bsdcp_pkg; no dependencies
`timescale 1ns / 1ps
module bsdcp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [52:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [52:0] quot
);
  localparam int NW = 53;
  logic [NW-1:0] q_r, q_nxt;
  logic [33:0]   rem_r, rem_nxt;
  logic [32:0]   d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [33:0]   trial;
  logic [33:0]   shifted;

  assign done = busy_r && (cnt_r == 6'd0);
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    shifted = {rem_r[32:0], q_r[NW-1]};
    trial = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt = num[52] ? NW'(-num) : NW'(num);
      d_nxt = den[32] ? 33'(-den) : 33'(den);
      neg_nxt = num[52] ^ den[32];
      rem_nxt = '0;
      cnt_nxt = 6'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        if (!trial[33]) begin
          rem_nxt = trial;
          q_nxt = {q_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          q_nxt = {q_r[NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
  end
endmodule

[tb/sv/bsdcp_checker.sv]
// checker for the b-spline derivative control point block: snoops config writes and
// both item channels, predicts every result and compares it field by field
// depends on bsdcp_pkg
`timescale 1ns / 1ps
module bsdcp_checker
  import bsdcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [6:0]         in_index,
  input  logic signed [31:0] in_knot_value,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [2:0]         in_read_order,
  input  logic [5:0]         in_read_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         st;
  } entry_t;

  logic [2:0] deg, order;
  logic [5:0] first, last;

  logic signed [31:0] knots [MaxKnotsDef];
  logic signed [31:0] pts   [MaxPointsDef][3];
  logic signed [31:0] dpts  [MaxOrderDef+1][MaxPointsDef][3];
  logic zero_span;
  logic built;
  int   built_range, built_order;

  entry_t entries_due[$];

  function automatic longint knot_at(longint idx);
    if (idx < 0 || idx >= MaxKnotsDef) return 0;
    return longint'(knots[idx]);
  endfunction

  // exact numerator, truncating divide, then clamp to q16.16
  function automatic logic signed [31:0] scaled_quotient(longint factor, longint diff,
                                                         longint span);
    longint q;
    q = (factor * diff * 65536) / span;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  task automatic build_triangle();
    int rng, ord;
    longint factor, span, base, diff;
    rng = int'(last) - int'(first);
    ord = int'(order);
    zero_span = 1'b0;
    if (ord > MaxOrderDef) ord = MaxOrderDef;
    if (rng > MaxPointsDef - 1) rng = MaxPointsDef - 1;
    built = 1'b1;
    built_range = rng;
    built_order = ord;
    if (rng < 0) return;
    for (int i = 0; i <= rng; i++)
      for (int c = 0; c < 3; c++) dpts[0][i][c] = pts[int'(first) + i][c];
    for (int k = 1; k <= ord; k++) begin
      factor = longint'(deg) - k + 1;
      for (int i = 0; i <= rng - k; i++) begin
        base = longint'(first) + i;
        span = knot_at(base + deg + 1) - knot_at(base + k);
        for (int c = 0; c < 3; c++) begin
          diff = longint'(dpts[k-1][i+1][c]) - longint'(dpts[k-1][i][c]);
          dpts[k][i][c] = (span == 0) ? 32'sd0 : scaled_quotient(factor, diff, span);
        end
        if (span == 0) zero_span = 1'b1;
      end
    end
  endtask

  task automatic predict_item();
    entry_t e;
    int k, i;
    e = '0;
    case (action_t'(in_action))
      ACT_LOAD_KNOT: knots[in_index] = in_knot_value;
      ACT_LOAD_POINT: begin
        if (in_index < MaxPointsDef) begin
          pts[in_index][0] = in_coord_x;
          pts[in_index][1] = in_coord_y;
          pts[in_index][2] = in_coord_z;
        end
      end
      ACT_COMPUTE: begin
        build_triangle();
        e.st = zero_span ? ST_ZERO_SPAN : ST_OK;
        entries_due.push_back(e);
      end
      default: begin
        k = int'(in_read_order);
        i = int'(in_read_index);
        if (built && k <= built_order && i <= built_range - k) begin
          e.x = dpts[k][i][0];
          e.y = dpts[k][i][1];
          e.z = dpts[k][i][2];
          e.st = zero_span ? ST_ZERO_SPAN : ST_OK;
        end else begin
          e.st = ST_OUTSIDE;
        end
        entries_due.push_back(e);
      end
    endcase
  endtask

  task automatic compare_result();
    entry_t e;
    if (entries_due.size() == 0) begin
      $display("%0t: result with none expected: x=%h y=%h z=%h status=%0d",
               $time, out_x, out_y, out_z, status);
      errors++;
      return;
    end
    e = entries_due.pop_front();
    if (out_x !== e.x) begin
      $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
      errors++;
    end
    if (out_y !== e.y) begin
      $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
      errors++;
    end
    if (out_z !== e.z) begin
      $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
      errors++;
    end
    if (status !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, status);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      deg = 3'd3;
      order = 3'd1;
      first = 6'd0;
      last = 6'd63;
      zero_span = 1'b0;
      built = 1'b0;
      built_range = -1;
      built_order = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEGREE: deg = cfg_data[2:0];
          REG_ORDER:  order = cfg_data[2:0];
          REG_FIRST:  first = cfg_data;
          REG_LAST:   last = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) predict_item();
    end
    pending = entries_due.size();
  end

endmodule

[tb/sv/testbench.sv]
// top of the b-spline derivative control point testbench: clock, reset, stimulus,
// receiver stalls and verdict; depends on bsdcp_pkg, bsdcp_checker and the block
`timescale 1ns / 1ps
module testbench
  import bsdcp_pkg::*;
();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [6:0] in_index = '0;
  logic signed [31:0] in_knot_value = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [2:0] in_read_order = '0;
  logic [5:0] in_read_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [1:0] status;
  int errors, pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  always #5 clk = ~clk;

  bspline_derivative_control_points i_dut (.*);

  bsdcp_checker i_checker (.*);

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(action_t a, logic [6:0] idx, logic [31:0] kv, logic [31:0] x,
                      logic [31:0] y, logic [31:0] z, logic [2:0] ro, logic [5:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= a;
    in_index <= idx;
    in_knot_value <= kv;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_read_order <= ro;
    in_read_index <= ri;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_read(int k, int i);
    send(ACT_READ, 7'($urandom), $urandom, $urandom, $urandom, $urandom, 3'(k), 6'(i));
  endtask

  task automatic send_compute();
    send(ACT_COMPUTE, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
         3'($urandom), 6'($urandom));
  endtask

  task automatic load_knot(int idx, logic [31:0] v);
    send(ACT_LOAD_KNOT, 7'(idx), v, $urandom, $urandom, $urandom, 3'($urandom),
         6'($urandom));
  endtask

  task automatic load_point(int idx);
    send(ACT_LOAD_POINT, 7'(idx), $urandom, rand_word(), rand_word(), rand_word(),
         3'($urandom), 6'($urandom));
  endtask

  // lets the block drain; loads give no result, so it keeps waiting after none is pending
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(int d, int o, int f, int l);
    int vals [4];
    vals = '{d, o, f, l};
    for (int r = 0; r < 4; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(r);
      cfg_data <= 6'(vals[r]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_round(int rnd);
    int d, o, f, l, rng, k, n;
    d = $urandom_range(1, 7);
    o = $urandom_range(0, 7);
    f = $urandom_range(0, 63);
    l = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : f + $urandom_range(0, 6);
    if (l > 63) l = 63;
    rng = l - f;
    set_config(d, o, f, l);
    for (int j = $urandom_range(0, 3); j > 0; j--) begin
      if ($urandom_range(1)) load_knot($urandom_range(0, 127), rand_word());
      else load_point($urandom_range(0, 127));
    end
    send_compute();
    // let the compute finish, then hold the receiver off so the reads that follow stall
    if (rnd % 9 == 4) begin
      wait_idle();
      hold_req = 1'b1;
    end
    n = $urandom_range(8, 16);
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(9))
        0: send_read($urandom_range(0, 7), $urandom_range(0, 63));
        1: load_point($urandom_range(0, 63));
        2: load_knot($urandom_range(0, 127), rand_word());
        default: begin
          k = (rng < 0) ? 0 : $urandom_range(0, (o < rng) ? o : rng);
          send_read(k, (rng - k < 0) ? 0 : $urandom_range(0, rng - k));
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read before any compute
    send_read(0, 0);
    // fill every knot and point so no compute touches an unwritten entry
    for (int j = 0; j < 128; j++)
      load_knot(j, (j % 11 == 5) ? 32'(((j - 1) * 300)) : 32'(j * 300));
    for (int j = 0; j < 64; j++) load_point(j);
    send_compute();
    send_read(0, 0);
    send_read(1, 62);
    send_read(1, 63);
    send_read(2, 0);
    send_read(0, 63);
    wait_idle();

    set_config(7, 7, 0, 63);
    send_compute();
    send_read(7, 56);
    send_read(7, 57);
    send_read(3, 10);
    wait_idle();

    // empty range
    set_config(1, 7, 63, 0);
    send_compute();
    send_read(0, 0);
    wait_idle();

    // rows past the range, order above degree
    set_config(1, 7, 60, 63);
    send_compute();
    send_read(3, 0);
    send_read(4, 0);
    send_read(2, 1);
    load_knot(127, 32'h80000000);
    load_point(100);
    load_point(61);
    send_read(1, 1);
    wait_idle();

    for (int rnd = 0; rnd < 34; rnd++) begin
      case ((rnd / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (rnd % 9 == 4) send_idle_pct = 0;
      random_round(rnd);
      wait_idle();
    end

    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[bspline_derivative_control_points.f]
rtl/core/bsdcp_pkg.sv
rtl/core/bsdcp_ram.sv
rtl/core/bsdcp_div.sv
rtl/core/bspline_derivative_control_points.sv
tb/sv/bsdcp_checker.sv
tb/sv/testbench.sv
